[rtl/bilinear_map_interpolator_unit_assert.svh]
// Assertion macros shared by the bilinear map interpolator RTL.
`ifndef BILINEAR_MAP_INTERPOLATOR_UNIT_ASSERT_SVH
`define BILINEAR_MAP_INTERPOLATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BMI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BMI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/bmi_pkg.sv]
// Package with field widths, codes and shared types of the bilinear map interpolator.
`default_nettype none

package bmi_pkg;

	localparam int CMD_W      = 1;
	localparam int ADDR_IN_W  = 10;
	localparam int ENTRY_W    = 16;
	localparam int IDX_W      = 10;
	localparam int RATIO_IN_W = 16;
	localparam int RES_W      = 33;
	localparam int ROWLEN_W   = 11;
	localparam int PROD_W     = IDX_W + ROWLEN_W;
	localparam int CALC_W     = 24;
	localparam int FRAC_W     = 16;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 2;

	localparam logic [CMD_W-1:0] CMD_WRITE  = 1'b0;
	localparam logic [CMD_W-1:0] CMD_INTERP = 1'b1;

	localparam logic [REG_IDX_W-1:0] REG_ROW_LENGTH   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_COLUMN_MAJOR = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_VALUE_SIGNED = 2'd2;

	localparam logic [ROWLEN_W-1:0] ROW_LENGTH_RESET = 11'd1;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} map_ctl_t;

endpackage

`default_nettype wire

[rtl/bmi_req_if.sv]
// Request channel of the bilinear map interpolator.
`default_nettype none

interface bmi_req_if;
	logic                            valid;
	logic                            ready;
	logic [bmi_pkg::CMD_W-1:0]       cmd;
	logic [bmi_pkg::ADDR_IN_W-1:0]   entry_address;
	logic [bmi_pkg::ENTRY_W-1:0]     entry_value;
	logic [bmi_pkg::IDX_W-1:0]       x_index;
	logic [bmi_pkg::RATIO_IN_W-1:0]  x_ratio;
	logic [bmi_pkg::IDX_W-1:0]       y_index;
	logic [bmi_pkg::RATIO_IN_W-1:0]  y_ratio;

	modport source (
		output valid, cmd, entry_address, entry_value, x_index, x_ratio, y_index, y_ratio,
		input  ready
	);

	modport sink (
		input  valid, cmd, entry_address, entry_value, x_index, x_ratio, y_index, y_ratio,
		output ready
	);
endinterface

`default_nettype wire

[rtl/bmi_rsp_if.sv]
// Result channel of the bilinear map interpolator.
`default_nettype none

interface bmi_rsp_if;
	logic                             valid;
	logic                             ready;
	logic signed [bmi_pkg::RES_W-1:0] result;
	logic                             index_error;

	modport source (
		output valid, result, index_error,
		input  ready
	);

	modport sink (
		input  valid, result, index_error,
		output ready
	);
endinterface

`default_nettype wire

[rtl/bilinear_map_interpolator_unit.sv]
// Top level of the bilinear map interpolator: register port, address pipeline and lerp datapath.
`default_nettype none

// The block takes one request per clock cycle when the result channel does not stall; a
// stall holds every occupied stage, while empty stages still fill. The map store is kept
// in two mirrored copies, each with two read ports, so all four corner entries of a cell
// are read in the same cycle. A write request updates the store when it leaves the
// address stage, so any later request sees it. The store has no reset and no clearing
// pass; entries read before being written are undefined. The pipeline runs: address
// product, corner addresses and range check, store read, y-axis products, y lerp and x
// difference, x-axis partial products, final sum with saturation to the result width.

module bilinear_map_interpolator_unit #(
	parameter int MAP_DEPTH  = 1024,
	parameter int VALUE_BITS = 16,
	parameter int RATIO_BITS = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	bmi_req_if.sink                               req,
	bmi_rsp_if.source                             rsp,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [bmi_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [bmi_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [bmi_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                  pready
);

	localparam int AW    = $clog2(MAP_DEPTH);
	localparam int CW    = VALUE_BITS + 1;
	localparam int DW    = CW + 1;
	localparam int PYW   = DW + RATIO_BITS + 1;
	localparam int LW    = CW + bmi_pkg::FRAC_W;
	localparam int XW    = LW + 1;
	localparam int HB    = RATIO_BITS / 2;
	localparam int PHW   = XW + (RATIO_BITS - HB) + 1;
	localparam int PLW   = XW + HB + 1;
	localparam int SUMW  = XW + RATIO_BITS + 1;
	localparam int SAT_W = (LW > bmi_pkg::RES_W) ? LW : bmi_pkg::RES_W;
	localparam int TYW   = PYW + bmi_pkg::FRAC_W;

	// Configuration registers.
	logic [bmi_pkg::ROWLEN_W-1:0] row_length_q;
	logic                         column_major_q;
	logic                         value_signed_q;
	logic                         cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q   <= bmi_pkg::ROW_LENGTH_RESET;
			column_major_q <= 1'b0;
			value_signed_q <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[bmi_pkg::APB_ADDR_W-1:2])
				bmi_pkg::REG_ROW_LENGTH: begin
					row_length_q <= pwdata[bmi_pkg::ROWLEN_W-1:0];
				end
				bmi_pkg::REG_COLUMN_MAJOR: begin
					column_major_q <= pwdata[0];
				end
				bmi_pkg::REG_VALUE_SIGNED: begin
					value_signed_q <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[bmi_pkg::APB_ADDR_W-1:2])
			bmi_pkg::REG_ROW_LENGTH:   prdata = bmi_pkg::APB_DATA_W'(row_length_q);
			bmi_pkg::REG_COLUMN_MAJOR: prdata = bmi_pkg::APB_DATA_W'(column_major_q);
			bmi_pkg::REG_VALUE_SIGNED: prdata = bmi_pkg::APB_DATA_W'(value_signed_q);
			default:                   prdata = '0;
		endcase
	end

	// Pipeline flow control: a stage loads when it is empty or its successor loads.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic adv1, adv2, adv3, adv4, adv5, adv6, adv7;

	assign adv7 = !v_s7 || rsp.ready;
	assign adv6 = !v_s6 || adv7;
	assign adv5 = !v_s5 || adv6;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;

	assign req.ready = adv1;
	assign rsp.valid = v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= req.valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
			if (adv6) v_s6 <= v_s5;
			if (adv7) v_s7 <= v_s6;
		end
	end

	// Stage 1: major index times row length, minor index plus neighbor offsets.
	logic [bmi_pkg::IDX_W-1:0]    major_idx, minor_idx;
	logic [bmi_pkg::ROWLEN_W-1:0] x_off, y_off;
	logic [RATIO_BITS-1:0]        x_rat, y_rat;

	assign major_idx = column_major_q ? req.y_index : req.x_index;
	assign minor_idx = column_major_q ? req.x_index : req.y_index;
	assign x_off     = column_major_q ? bmi_pkg::ROWLEN_W'(1) : row_length_q;
	assign y_off     = column_major_q ? row_length_q : bmi_pkg::ROWLEN_W'(1);
	assign x_rat     = RATIO_BITS'(req.x_ratio);
	assign y_rat     = RATIO_BITS'(req.y_ratio);

	logic [bmi_pkg::CMD_W-1:0]     cmd_s1;
	logic [bmi_pkg::ADDR_IN_W-1:0] waddr_s1;
	logic [VALUE_BITS-1:0]         wdata_s1;
	logic [bmi_pkg::PROD_W-1:0]    prod_s1;
	logic [bmi_pkg::CALC_W-1:0]    m00_s1, m01_s1, m10_s1, m11_s1;
	logic [RATIO_BITS-1:0]         xr_s1, yr_s1;
	logic                          need_x_s1, need_y_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			cmd_s1    <= req.cmd;
			waddr_s1  <= req.entry_address;
			wdata_s1  <= VALUE_BITS'(req.entry_value);
			prod_s1   <= bmi_pkg::PROD_W'(major_idx) * bmi_pkg::PROD_W'(row_length_q);
			m00_s1    <= bmi_pkg::CALC_W'(minor_idx);
			m01_s1    <= bmi_pkg::CALC_W'(minor_idx) + bmi_pkg::CALC_W'(y_off);
			m10_s1    <= bmi_pkg::CALC_W'(minor_idx) + bmi_pkg::CALC_W'(x_off);
			m11_s1    <= bmi_pkg::CALC_W'(minor_idx) + bmi_pkg::CALC_W'(x_off)
				+ bmi_pkg::CALC_W'(y_off);
			xr_s1     <= x_rat;
			yr_s1     <= y_rat;
			need_x_s1 <= |x_rat;
			need_y_s1 <= |y_rat;
		end
	end

	// Stage 2: corner addresses and the range check against the store depth.
	logic [bmi_pkg::CALC_W-1:0] a00, a01, a10, a11, wa_full, depth;
	logic                       err_rd, err_wr;

	assign depth   = bmi_pkg::CALC_W'(MAP_DEPTH);
	assign a00     = bmi_pkg::CALC_W'(prod_s1) + m00_s1;
	assign a01     = bmi_pkg::CALC_W'(prod_s1) + m01_s1;
	assign a10     = bmi_pkg::CALC_W'(prod_s1) + m10_s1;
	assign a11     = bmi_pkg::CALC_W'(prod_s1) + m11_s1;
	assign wa_full = bmi_pkg::CALC_W'(waddr_s1);
	assign err_wr  = wa_full >= depth;
	assign err_rd  = (a00 >= depth) || (need_y_s1 && (a01 >= depth))
		|| (need_x_s1 && (a10 >= depth)) || (need_x_s1 && need_y_s1 && (a11 >= depth));

	logic [bmi_pkg::CMD_W-1:0] cmd_s2;
	logic                      err_s2;
	logic [AW-1:0]             waddr_s2;
	logic [VALUE_BITS-1:0]     wdata_s2;
	logic [3:0][AW-1:0]        raddr_s2;
	logic [RATIO_BITS-1:0]     xr_s2, yr_s2;
	logic                      need_x_s2, need_y_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			cmd_s2      <= cmd_s1;
			err_s2      <= (cmd_s1 == bmi_pkg::CMD_WRITE) ? err_wr : err_rd;
			waddr_s2    <= wa_full[AW-1:0];
			wdata_s2    <= wdata_s1;
			raddr_s2[0] <= a00[AW-1:0];
			raddr_s2[1] <= a01[AW-1:0];
			raddr_s2[2] <= a10[AW-1:0];
			raddr_s2[3] <= a11[AW-1:0];
			xr_s2       <= xr_s1;
			yr_s2       <= yr_s1;
			need_x_s2   <= need_x_s1;
			need_y_s2   <= need_y_s1;
		end
	end

	// Stage 3: store access; writes and reads happen as the request leaves stage 2.
	bmi_pkg::map_ctl_t           map_ctl;
	logic [3:0][VALUE_BITS-1:0]  map_rd;

	assign map_ctl.rd_en = adv3;
	assign map_ctl.wr_en = adv3 && v_s2 && (cmd_s2 == bmi_pkg::CMD_WRITE) && !err_s2;

	bmi_map_store #(
		.DEPTH  (MAP_DEPTH),
		.DATA_W (VALUE_BITS),
		.ADDR_W (AW)
	) u_store (
		.clk   (clk),
		.ctl   (map_ctl),
		.waddr (waddr_s2),
		.wdata (wdata_s2),
		.raddr (raddr_s2),
		.rdata (map_rd)
	);

	logic [bmi_pkg::CMD_W-1:0] cmd_s3;
	logic                      err_s3;
	logic [RATIO_BITS-1:0]     xr_s3, yr_s3;
	logic                      need_x_s3, need_y_s3;

	always_ff @(posedge clk) begin
		if (adv3) begin
			cmd_s3    <= cmd_s2;
			err_s3    <= err_s2;
			xr_s3     <= xr_s2;
			yr_s3     <= yr_s2;
			need_x_s3 <= need_x_s2;
			need_y_s3 <= need_y_s2;
		end
	end

	// Stage 4: corner values, y differences and their products with the y ratio.
	// Corners an axis does not need are kept out of the arithmetic.
	logic signed [CW-1:0]  c00, c01, c10, c11;
	logic signed [DW-1:0]  d0, d1;
	logic signed [PYW-1:0] py0, py1;

	assign c00 = {value_signed_q & map_rd[0][VALUE_BITS-1], map_rd[0]};
	assign c01 = {value_signed_q & map_rd[1][VALUE_BITS-1], map_rd[1]};
	assign c10 = {value_signed_q & map_rd[2][VALUE_BITS-1], map_rd[2]};
	assign c11 = {value_signed_q & map_rd[3][VALUE_BITS-1], map_rd[3]};
	assign d0  = need_y_s3 ? (DW'(c01) - DW'(c00)) : '0;
	assign d1  = (need_x_s3 && need_y_s3) ? (DW'(c11) - DW'(c10)) : '0;
	assign py0 = d0 * $signed({1'b0, yr_s3});
	assign py1 = d1 * $signed({1'b0, yr_s3});

	logic [bmi_pkg::CMD_W-1:0] cmd_s4;
	logic                      err_s4;
	logic [RATIO_BITS-1:0]     xr_s4;
	logic                      need_x_s4;
	logic signed [CW-1:0]      c00_s4, c10_s4;
	logic signed [PYW-1:0]     py0_s4, py1_s4;

	always_ff @(posedge clk) begin
		if (adv4) begin
			cmd_s4    <= cmd_s3;
			err_s4    <= err_s3;
			xr_s4     <= xr_s3;
			need_x_s4 <= need_x_s3;
			c00_s4    <= c00;
			c10_s4    <= need_x_s3 ? c10 : '0;
			py0_s4    <= py0;
			py1_s4    <= py1;
		end
	end

	// Stage 5: y lerps in Q.16 with floored products, then the x difference.
	logic signed [TYW-1:0] ty0, ty1, lo_full, hi_full;
	logic signed [LW-1:0]  lo_y, hi_y;
	logic signed [XW-1:0]  xd;

	assign ty0     = $signed({py0_s4, {bmi_pkg::FRAC_W{1'b0}}}) >>> RATIO_BITS;
	assign ty1     = $signed({py1_s4, {bmi_pkg::FRAC_W{1'b0}}}) >>> RATIO_BITS;
	assign lo_full = TYW'($signed({c00_s4, {bmi_pkg::FRAC_W{1'b0}}})) + ty0;
	assign hi_full = TYW'($signed({c10_s4, {bmi_pkg::FRAC_W{1'b0}}})) + ty1;
	assign lo_y    = lo_full[LW-1:0];
	assign hi_y    = hi_full[LW-1:0];
	assign xd      = need_x_s4 ? (XW'(hi_y) - XW'(lo_y)) : '0;

	logic [bmi_pkg::CMD_W-1:0] cmd_s5;
	logic                      err_s5;
	logic [RATIO_BITS-1:0]     xr_s5;
	logic signed [LW-1:0]      lo_s5;
	logic signed [XW-1:0]      xd_s5;

	always_ff @(posedge clk) begin
		if (adv5) begin
			cmd_s5 <= cmd_s4;
			err_s5 <= err_s4;
			xr_s5  <= xr_s4;
			lo_s5  <= lo_y;
			xd_s5  <= xd;
		end
	end

	// Stage 6: x difference times the upper and lower halves of the x ratio.
	logic signed [PHW-1:0] pxh;
	logic signed [PLW-1:0] pxl;

	assign pxh = xd_s5 * $signed({1'b0, xr_s5[RATIO_BITS-1:HB]});
	assign pxl = xd_s5 * $signed({1'b0, xr_s5[HB-1:0]});

	logic [bmi_pkg::CMD_W-1:0] cmd_s6;
	logic                      err_s6;
	logic signed [LW-1:0]      lo_s6;
	logic signed [PHW-1:0]     pxh_s6;
	logic signed [PLW-1:0]     pxl_s6;

	always_ff @(posedge clk) begin
		if (adv6) begin
			cmd_s6 <= cmd_s5;
			err_s6 <= err_s5;
			lo_s6  <= lo_s5;
			pxh_s6 <= pxh;
			pxl_s6 <= pxl;
		end
	end

	// Stage 7: x lerp, saturation to the result range, zero for writes and errors.
	logic signed [SUMW-1:0]            px_sum, tx;
	logic signed [LW-1:0]              res_l;
	logic signed [SAT_W-1:0]           res_ext;
	logic                              res_fits;
	logic signed [bmi_pkg::RES_W-1:0]  res_sat, res_out;

	assign px_sum   = (SUMW'(pxh_s6) <<< HB) + SUMW'(pxl_s6);
	assign tx       = px_sum >>> RATIO_BITS;
	assign res_l    = lo_s6 + LW'(tx);
	assign res_ext  = SAT_W'(res_l);
	assign res_fits = res_ext[SAT_W-1:bmi_pkg::RES_W-1]
		== {(SAT_W - bmi_pkg::RES_W + 1){res_ext[SAT_W-1]}};
	assign res_sat  = res_fits ? res_ext[bmi_pkg::RES_W-1:0]
		: {res_ext[SAT_W-1], {(bmi_pkg::RES_W - 1){~res_ext[SAT_W-1]}}};
	assign res_out  = ((cmd_s6 == bmi_pkg::CMD_INTERP) && !err_s6) ? res_sat : '0;

	logic [bmi_pkg::CMD_W-1:0]         cmd_s7;
	logic                              err_s7;
	logic signed [bmi_pkg::RES_W-1:0]  res_s7;

	always_ff @(posedge clk) begin
		if (adv7) begin
			cmd_s7 <= cmd_s6;
			err_s7 <= err_s6;
			res_s7 <= res_out;
		end
	end

	assign rsp.result      = res_s7;
	assign rsp.index_error = err_s7;

	`include "bilinear_map_interpolator_unit_assert.svh"

	`BMI_ASSERT_IMP(a_err_zero, clk, arst_n, v_s7 && err_s7, res_s7 == '0, "error result is not zero")
	`BMI_ASSERT_IMP(a_write_zero, clk, arst_n, v_s7 && (cmd_s7 == bmi_pkg::CMD_WRITE), res_s7 == '0, "write result is not zero")
	`BMI_ASSERT_IMP(a_full_stall, clk, arst_n, v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && v_s7 && !rsp.ready, !req.ready, "request taken into a full stalled pipeline")
	`BMI_ASSERT_NXT(a_rd_hold, clk, arst_n, v_s3 && !adv4, $stable(map_rd), "store read data changed under a stall")

endmodule

`default_nettype wire

[rtl/bmi_map_store.sv]
// Map store: two mirrored copies with one write port and four registered read ports.
`default_nettype none

module bmi_map_store #(
	parameter int DEPTH  = 1024,
	parameter int DATA_W = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic                        clk,
	input  wire bmi_pkg::map_ctl_t           ctl,
	input  wire logic [ADDR_W-1:0]           waddr,
	input  wire logic [DATA_W-1:0]           wdata,
	input  wire logic [3:0][ADDR_W-1:0]      raddr,
	output logic      [3:0][DATA_W-1:0]      rdata
);

	logic [DATA_W-1:0] mem_a [DEPTH];
	logic [DATA_W-1:0] mem_b [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_a[waddr] <= wdata;
			mem_b[waddr] <= wdata;
		end
		if (ctl.rd_en) begin
			rdata[0] <= mem_a[raddr[0]];
			rdata[1] <= mem_a[raddr[1]];
			rdata[2] <= mem_b[raddr[2]];
			rdata[3] <= mem_b[raddr[3]];
		end
	end

endmodule

`default_nettype wire
